### rtl/crc8w_pkg.sv
// Shared types, constants and the CRC-8 byte update for the word response deframer.
`timescale 1ns / 1ps
package crc8w_pkg;

	localparam logic [7:0] CRC_START = 8'hFF;
	localparam logic [7:0] CRC_POLY  = 8'h31;

	localparam logic [1:0] POS_HIGH  = 2'd0;
	localparam logic [1:0] POS_LOW   = 2'd1;
	localparam logic [1:0] POS_CHECK = 2'd2;

	typedef struct packed {
		logic [31:0] word_value;
		logic        word_crc_ok;
		logic        response_ok;
		logic        last_word;
	} crc8w_res_t;

	typedef struct packed {
		logic       load;
		crc8w_res_t res;
	} crc8w_handoff_t;

	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/crc8w_ifs.sv
// Byte input and word output channel interfaces.
`timescale 1ns / 1ps
interface crc8w_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_response;

	modport source (output valid, output rx_byte, output end_of_response, input ready);
	modport sink (input valid, input rx_byte, input end_of_response, output ready);
endinterface

interface crc8w_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word_value;
	logic        word_crc_ok;
	logic        response_ok;
	logic        last_word;

	modport source (output valid, output word_value, output word_crc_ok,
		output response_ok, output last_word, input ready);
	modport sink (input valid, input word_value, input word_crc_ok,
		input response_ok, input last_word, output ready);
endinterface

### rtl/crc8w_core.sv
// Input register, group and word assembly state, and CRC check.
`timescale 1ns / 1ps
module crc8w_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    mode_we,
	input  logic                    mode_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              in_byte,
	input  logic                    in_eor,
	input  logic                    out_free,
	output crc8w_pkg::crc8w_handoff_t handoff
);
	import crc8w_pkg::*;

	logic        mode_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eor_s1;
	logic [1:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] partial_q;
	logic [15:0] high_q;
	logic        phase_q;
	logic        hok_q;
	logic        err_q;

	logic [1:0]  pos_n;
	logic [7:0]  crc_n;
	logic [15:0] partial_n;
	logic [15:0] high_n;
	logic        phase_n;
	logic        hok_n;
	logic        err_n;
	logic        emit;
	logic        ok;
	crc8w_res_t  res;
	logic        advance;

	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_comb begin
		pos_n     = pos_q;
		crc_n     = crc_q;
		partial_n = partial_q;
		high_n    = high_q;
		phase_n   = phase_q;
		hok_n     = hok_q;
		err_n     = err_q;
		emit      = 1'b0;
		ok        = (byte_s1 == crc_q);
		res       = '0;
		case (pos_q)
			POS_LOW: begin
				partial_n = {partial_q[15:8], byte_s1};
				crc_n     = crc8_feed(crc_q, byte_s1);
				pos_n     = POS_CHECK;
			end
			POS_CHECK: begin
				err_n = err_q | !ok;
				pos_n = POS_HIGH;
				crc_n = CRC_START;
				if (!mode_q) begin
					phase_n = 1'b0;
					hok_n   = 1'b1;
					emit    = 1'b1;
					res.word_value  = {16'h0000, partial_q};
					res.word_crc_ok = ok;
				end else if (!phase_q) begin
					high_n  = partial_q;
					hok_n   = ok;
					phase_n = 1'b1;
				end else begin
					phase_n = 1'b0;
					hok_n   = 1'b1;
					emit    = 1'b1;
					res.word_value  = {high_q, partial_q};
					res.word_crc_ok = ok & hok_q;
				end
				res.response_ok = !err_n;
				res.last_word   = eor_s1;
			end
			default: begin
				partial_n = {byte_s1, 8'h00};
				crc_n     = crc8_feed(CRC_START, byte_s1);
				pos_n     = POS_LOW;
			end
		endcase
		if (eor_s1) begin
			if (!emit) begin
				emit = 1'b1;
				res  = '0;
				res.last_word = 1'b1;
			end
			pos_n     = POS_HIGH;
			crc_n     = CRC_START;
			partial_n = '0;
			high_n    = '0;
			phase_n   = 1'b0;
			hok_n     = 1'b1;
			err_n     = 1'b0;
		end
	end

	assign handoff = {advance && emit, res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			valid_s1  <= 1'b0;
			pos_q     <= POS_HIGH;
			crc_q     <= CRC_START;
			partial_q <= '0;
			high_q    <= '0;
			phase_q   <= 1'b0;
			hok_q     <= 1'b1;
			err_q     <= 1'b0;
		end else begin
			if (mode_we) begin
				mode_q <= mode_wdata;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				pos_q     <= pos_n;
				crc_q     <= crc_n;
				partial_q <= partial_n;
				high_q    <= high_n;
				phase_q   <= phase_n;
				hok_q     <= hok_n;
				err_q     <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eor_s1  <= in_eor;
		end
	end

endmodule

### rtl/crc8w_result_reg.sv
// Result register holding one finished word until the receiver takes it.
`timescale 1ns / 1ps
module crc8w_result_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  crc8w_pkg::crc8w_handoff_t handoff,
	output logic                      out_free,
	output logic                      out_valid,
	input  logic                      out_ready,
	output crc8w_pkg::crc8w_res_t     out_res
);
	import crc8w_pkg::*;

	logic       valid_q;
	crc8w_res_t res_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= handoff.load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && handoff.load) begin
			res_q <= handoff.res;
		end
	end

endmodule

### rtl/crc8_word_response_deframer_top.sv
// Top level of the CRC-8 word response deframer.
// Usage:
//   byte_in takes one byte a cycle while ready (rx_byte, end_of_response).
//   Groups are two data bytes then a CRC-8 check byte (poly 0x31, start 0xFF).
//   word_out gives one word per group (mode 0) or per two groups (mode 1,
//   first group in the high half), with word_crc_ok, response_ok, last_word.
//   mode_we/mode_wdata write word_size_mode; write it only while idle.
// Timing:
//   A byte is registered in the input register and is then processed into the
//   result register once that is free; the word that the byte completes is
//   valid on word_out from the result register. One byte per cycle is sustained
//   while word_out is not held; the CRC byte update is one XOR network.
// Reset:
//   arst_n clears all group state, the mode (16-bit) and both valid flags.
// Stall:
//   While word_out is held the result register keeps its word and the input
//   register takes no further byte once it is full; nothing is dropped.
`timescale 1ns / 1ps
module crc8_word_response_deframer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic mode_we,
	input  logic mode_wdata,
	crc8w_byte_if.sink   byte_in,
	crc8w_word_if.source word_out
);
	import crc8w_pkg::*;

	crc8w_handoff_t handoff;
	crc8w_res_t     res;
	logic           out_free;

	crc8w_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.in_valid   (byte_in.valid),
		.in_ready   (byte_in.ready),
		.in_byte    (byte_in.rx_byte),
		.in_eor     (byte_in.end_of_response),
		.out_free   (out_free),
		.handoff    (handoff)
	);

	crc8w_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.handoff   (handoff),
		.out_free  (out_free),
		.out_valid (word_out.valid),
		.out_ready (word_out.ready),
		.out_res   (res)
	);

	assign word_out.word_value  = res.word_value;
	assign word_out.word_crc_ok = res.word_crc_ok;
	assign word_out.response_ok = res.response_ok;
	assign word_out.last_word   = res.last_word;

endmodule

### test/crc8_word_response_deframer_top_test.sv
// Self-checking testbench for the CRC-8 word response deframer top level.
`timescale 1ns / 1ps
module crc8_word_response_deframer_top_test;

	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 6;

	logic clk = 1'b0;
	logic arst_n;
	logic mode_we;
	logic mode_wdata;

	crc8w_byte_if byte_ch ();
	crc8w_word_if word_ch ();

	crc8_word_response_deframer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.byte_in    (byte_ch),
		.word_out   (word_ch)
	);

	always #5 clk = ~clk;

	// deframer state as the block should hold it
	logic        wide_mode  = 1'b0;
	logic [1:0]  grp_pos    = crc8w_pkg::POS_HIGH;
	logic [7:0]  run_crc    = crc8w_pkg::CRC_START;
	logic [15:0] part_word  = 16'h0000;
	logic [15:0] hi_half    = 16'h0000;
	logic        hi_pending = 1'b0;
	logic        hi_ok      = 1'b1;
	logic        resp_err   = 1'b0;

	crc8w_pkg::crc8w_res_t words_due[$];
	crc8w_pkg::crc8w_res_t oldest_word;

	int unsigned mismatches  = 0;
	int unsigned bytes_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned quiet_ticks = 0;
	logic [31:0] stall_map   = 32'hFFFF_FFFF;
	logic [5:0]  stall_tick  = 6'd0;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r  = {r[6:0], 1'b0} ^ (fb ? crc8w_pkg::CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	function automatic logic [15:0] pick_data();
		int unsigned k;
		k = $urandom_range(0, 7);
		return (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic eor);
		crc8w_pkg::crc8w_res_t w;
		logic                  made;
		logic                  ok;
		made = 1'b0;
		w    = '0;
		case (grp_pos)
			crc8w_pkg::POS_LOW: begin
				part_word[7:0] = b;
				run_crc        = crc_step(run_crc, b);
				grp_pos        = crc8w_pkg::POS_CHECK;
			end
			crc8w_pkg::POS_CHECK: begin
				ok = (b == run_crc);
				if (!ok) begin
					resp_err = 1'b1;
				end
				grp_pos = crc8w_pkg::POS_HIGH;
				run_crc = crc8w_pkg::CRC_START;
				if (!wide_mode) begin
					hi_pending = 1'b0;
					hi_ok      = 1'b1;
					w = '{word_value: {16'h0000, part_word}, word_crc_ok: ok,
						response_ok: !resp_err, last_word: eor};
					made = 1'b1;
				end else if (!hi_pending) begin
					hi_half    = part_word;
					hi_ok      = ok;
					hi_pending = 1'b1;
				end else begin
					w = '{word_value: {hi_half, part_word}, word_crc_ok: ok & hi_ok,
						response_ok: !resp_err, last_word: eor};
					hi_pending = 1'b0;
					hi_ok      = 1'b1;
					made       = 1'b1;
				end
			end
			default: begin
				part_word = {b, 8'h00};
				run_crc   = crc_step(crc8w_pkg::CRC_START, b);
				grp_pos   = crc8w_pkg::POS_LOW;
			end
		endcase
		if (eor) begin
			if (!made) begin
				resp_err = 1'b1;
				w = '{word_value: 32'h0, word_crc_ok: 1'b0, response_ok: 1'b0,
					last_word: 1'b1};
				made = 1'b1;
			end
			grp_pos    = crc8w_pkg::POS_HIGH;
			run_crc    = crc8w_pkg::CRC_START;
			part_word  = 16'h0000;
			hi_half    = 16'h0000;
			hi_pending = 1'b0;
			hi_ok      = 1'b1;
			resp_err   = 1'b0;
		end
		if (made) begin
			words_due.push_back(w);
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			deframe_byte(byte_ch.rx_byte, byte_ch.end_of_response);
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_ch.valid && word_ch.ready) begin
			if (words_due.size() == 0) begin
				$display("%0t: word expected none, got %h crc_ok %b resp_ok %b last %b",
					$time, word_ch.word_value, word_ch.word_crc_ok, word_ch.response_ok,
					word_ch.last_word);
				mismatches++;
			end else begin
				oldest_word = words_due.pop_front();
				compare_field("word_value", oldest_word.word_value, word_ch.word_value);
				compare_field("word_crc_ok", 32'(oldest_word.word_crc_ok),
					32'(word_ch.word_crc_ok));
				compare_field("response_ok", 32'(oldest_word.response_ok),
					32'(word_ch.response_ok));
				compare_field("last_word", 32'(oldest_word.last_word),
					32'(word_ch.last_word));
			end
		end
	end

	always @(negedge clk) begin
		if (stall_tick == 6'd0) begin
			case ($urandom_range(0, 3))
				0: stall_map = 32'hFFFF_FFFF;
				1: stall_map = $urandom;
				2: stall_map = $urandom | $urandom;
				default: stall_map = $urandom & $urandom;
			endcase
		end
		word_ch.ready <= stall_map[0];
		stall_map = {stall_map[0], stall_map[31:1]};
		stall_tick++;
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (word_ch.valid && word_ch.ready)) begin
			quiet_ticks <= 0;
		end else begin
			quiet_ticks <= quiet_ticks + 1;
		end
		if (quiet_ticks >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eor);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				byte_ch.valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		byte_ch.valid           <= 1'b1;
		byte_ch.rx_byte         <= b;
		byte_ch.end_of_response <= eor;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_group(input logic [15:0] data, input logic good, input logic eor);
		logic [7:0] chk;
		chk = crc_step(crc_step(crc8w_pkg::CRC_START, data[15:8]), data[7:0]);
		if (!good) begin
			chk ^= 8'($urandom_range(1, 255));
		end
		send_byte(data[15:8], 1'b0);
		send_byte(data[7:0], 1'b0);
		send_byte(chk, eor);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_word_mode(input logic v);
		@(negedge clk);
		mode_we    <= 1'b1;
		mode_wdata <= v;
		@(posedge clk);
		wide_mode = v;
		@(negedge clk);
		mode_we <= 1'b0;
	endtask

	task automatic test_plain_words();
		set_word_mode(1'b0);
		send_group(16'h0000, 1'b1, 1'b0);
		send_group(16'hFFFF, 1'b0, 1'b0);
		send_group(16'h8001, 1'b1, 1'b1);
	endtask

	task automatic test_truncated_responses();
		send_byte(8'hA5, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_joined_words();
		drain_pipeline();
		set_word_mode(1'b1);
		send_group(16'hFFFF, 1'b1, 1'b0);
		send_group(16'h0000, 1'b0, 1'b1);
		send_group(16'h3F80, 1'b1, 1'b1);
	endtask

	task automatic test_mode_change_midway();
		send_group(16'h1234, 1'b1, 1'b0);
		drain_pipeline();
		set_word_mode(1'b0);
		send_group(16'hABCD, 1'b1, 1'b1);
	endtask

	task automatic test_random_responses();
		int unsigned stop_at;
		int unsigned phase_end;
		int unsigned kind;
		int unsigned groups;
		stop_at   = bytes_sent + 850;
		phase_end = 0;
		while (bytes_sent < stop_at) begin
			if (bytes_sent >= phase_end) begin
				drain_pipeline();
				set_word_mode(1'($urandom_range(0, 1)));
				phase_end = bytes_sent + $urandom_range(40, 160);
			end
			kind = $urandom_range(0, 15);
			if (kind < 12) begin
				groups = $urandom_range(1, 4) * (wide_mode ? 2 : 1);
				for (int g = 0; g < groups; g++) begin
					send_group(pick_data(), $urandom_range(0, 15) != 0, g == groups - 1);
				end
			end else if (kind < 14) begin
				groups = $urandom_range(0, 3);
				for (int g = 0; g < groups; g++) begin
					send_group(pick_data(), 1'b1, 1'b0);
				end
				if ($urandom_range(0, 1) == 0) begin
					send_byte(8'($urandom_range(0, 255)), 1'b1);
				end else begin
					send_byte(8'($urandom_range(0, 255)), 1'b0);
					send_byte(8'($urandom_range(0, 255)), 1'b1);
				end
			end else if (kind == 14) begin
				repeat ($urandom_range(1, 6)) begin
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				end
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				// leave the response open and flip the word size under it
				send_group(pick_data(), 1'b1, 1'b0);
				drain_pipeline();
				set_word_mode(!wide_mode);
			end
		end
	endtask

	initial begin
		arst_n                  = 1'b0;
		mode_we                 = 1'b0;
		mode_wdata              = 1'b0;
		byte_ch.valid           = 1'b0;
		byte_ch.rx_byte         = 8'h00;
		byte_ch.end_of_response = 1'b0;
		word_ch.ready           = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_plain_words();
		test_truncated_responses();
		test_joined_words();
		test_mode_change_midway();
		test_random_responses();
		drain_pipeline();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/crc8w_pkg.sv
rtl/crc8w_ifs.sv
rtl/crc8w_core.sv
rtl/crc8w_result_reg.sv
rtl/crc8_word_response_deframer_top.sv
test/crc8_word_response_deframer_top_test.sv
